@@ src/per_id_read_reorder_buffer_unit_macros.svh @@
// Assertion helpers shared by the reorder buffer modules.
// Both expect clk and rst_n in scope.
`ifndef PER_ID_READ_REORDER_BUFFER_UNIT_MACROS_SVH
`define PER_ID_READ_REORDER_BUFFER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PRRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("prrb: invariant violated");
`define PRRB_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("prrb: sequence violated");
`else
`define PRRB_ASSERT(lbl, prop)
`define PRRB_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

@@ src/prrb_pkg.sv @@
`default_nettype none
package prrb_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = 6;
  localparam int ID_COUNT = 16;
  localparam int ID_W     = 4;
  localparam int OCC_W    = 7;

  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_RETURN = 2'd1;
  localparam logic [1:0] FN_POP    = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_BAD   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } prrb_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } prrb_cmd_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ src/prrb_ctrl.sv @@
`default_nettype none
`include "per_id_read_reorder_buffer_unit_macros.svh"
module prrb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output prrb_pkg::prrb_cmd_t    cmd
);

  prrb_pkg::prrb_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prrb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      prrb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = prrb_pkg::ST_LOOKUP;
        end
      end
      prrb_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = prrb_pkg::ST_COMMIT;
      end
      prrb_pkg::ST_COMMIT: begin
        // hold the item until the output register can take its result
        if (out_free) begin
          cmd.commit = 1'b1;
          in_tready  = 1'b1;
          if (in_tvalid) begin
            cmd.capture = 1'b1;
            state_nxt   = prrb_pkg::ST_LOOKUP;
          end else begin
            state_nxt = prrb_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = prrb_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  `PRRB_ASSERT_NEXT(a_capture_to_lookup, in_tvalid && in_tready, state_r == prrb_pkg::ST_LOOKUP)
  `PRRB_ASSERT_NEXT(a_lookup_to_commit, state_r == prrb_pkg::ST_LOOKUP, state_r == prrb_pkg::ST_COMMIT)

endmodule
`default_nettype wire

@@ src/prrb_dpath.sv @@
`default_nettype none
`include "per_id_read_reorder_buffer_unit_macros.svh"
module prrb_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire prrb_pkg::prrb_cmd_t          cmd,
  input  wire logic [1:0]                   in_func,
  input  wire logic [prrb_pkg::ID_W-1:0]    in_txn_id,
  input  wire logic [prrb_pkg::SLOT_W-1:0]  in_slot,
  output logic [1:0]                        res_status,
  output logic [prrb_pkg::SLOT_W-1:0]       res_slot,
  output logic [prrb_pkg::ID_W-1:0]         res_id,
  output logic [prrb_pkg::OCC_W-1:0]        res_occ
);

  localparam int SLOTS    = prrb_pkg::SLOTS;
  localparam int SLOT_W   = prrb_pkg::SLOT_W;
  localparam int ID_COUNT = prrb_pkg::ID_COUNT;
  localparam int ID_W     = prrb_pkg::ID_W;
  localparam int OCC_W    = prrb_pkg::OCC_W;

  // captured item
  logic [1:0]        func_r;
  logic [ID_W-1:0]   id_r;
  logic [SLOT_W-1:0] slot_r;

  // slot bitmaps
  logic [SLOTS-1:0] free_r, free_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] head_r, head_nxt;
  logic [SLOTS-1:0] next_ok_r, next_ok_nxt;

  // per-ID list tails
  logic [ID_COUNT-1:0][SLOT_W-1:0] tail_r, tail_nxt;
  logic [ID_COUNT-1:0]             tail_ok_r, tail_ok_nxt;

  logic [OCC_W-1:0]  used_r, used_nxt;
  logic [SLOT_W-1:0] rr_r, rr_nxt;

  // slot memories
  logic [ID_W-1:0]   owner_mem [SLOTS];
  logic [SLOT_W-1:0] next_mem  [SLOTS];
  logic [ID_W-1:0]   owner_rd_r;
  logic [SLOT_W-1:0] next_rd_r;
  logic              owner_we, next_we;
  logic [SLOT_W-1:0] next_waddr;
  logic [SLOT_W-1:0] owner_raddr;

  // lookup results
  logic [SLOT_W-1:0] alloc_slot, alloc_slot_r;
  logic              alloc_ok_r;
  logic [SLOT_W-1:0] grant_slot, grant_slot_r;
  logic              grant_ok_r;
  logic [SLOTS-1:0]  ready_vec, hi_mask, ready_hi;

  // output register
  logic [1:0]        status_r, status_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic [SLOT_W-1:0] tail_slot;
  logic              bad_ret;

  assign res_status = status_r;
  assign res_slot   = oslot_r;
  assign res_id     = oid_r;
  assign res_occ    = occ_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      id_r   <= in_txn_id;
      slot_r <= in_slot;
    end
  end

  // lowest free slot, and round-robin grant starting after rr_r
  always_comb begin
    alloc_slot  = prrb_pkg::lowest_set(free_r);
    ready_vec   = head_r & valid_r;
    hi_mask     = ({SLOTS{1'b1}} << rr_r) << 1;
    ready_hi    = ready_vec & hi_mask;
    grant_slot  = (|ready_hi) ? prrb_pkg::lowest_set(ready_hi)
                              : prrb_pkg::lowest_set(ready_vec);
    owner_raddr = (func_r == prrb_pkg::FN_POP) ? grant_slot : slot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      alloc_slot_r <= alloc_slot;
      alloc_ok_r   <= |free_r;
      grant_slot_r <= grant_slot;
      grant_ok_r   <= |ready_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (owner_we) owner_mem[alloc_slot_r] <= id_r;
    if (next_we) next_mem[next_waddr] <= alloc_slot_r;
    if (cmd.lookup) begin
      owner_rd_r <= owner_mem[owner_raddr];
      next_rd_r  <= next_mem[grant_slot];
    end
  end

  always_comb begin
    free_nxt    = free_r;
    valid_nxt   = valid_r;
    head_nxt    = head_r;
    next_ok_nxt = next_ok_r;
    tail_nxt    = tail_r;
    tail_ok_nxt = tail_ok_r;
    used_nxt    = used_r;
    rr_nxt      = rr_r;
    status_nxt  = status_r;
    oslot_nxt   = oslot_r;
    oid_nxt     = oid_r;
    occ_nxt     = occ_r;
    owner_we    = 1'b0;
    next_we     = 1'b0;
    tail_slot   = tail_r[id_r];
    next_waddr  = tail_slot;
    bad_ret     = free_r[slot_r] || (owner_rd_r != id_r) || valid_r[slot_r];
    if (cmd.commit) begin
      status_nxt = prrb_pkg::STS_OK;
      oslot_nxt  = '0;
      oid_nxt    = '0;
      unique case (func_r)
        prrb_pkg::FN_ALLOC: begin
          if (!alloc_ok_r) begin
            status_nxt = prrb_pkg::STS_FULL;
          end else begin
            free_nxt[alloc_slot_r]    = 1'b0;
            valid_nxt[alloc_slot_r]   = 1'b0;
            next_ok_nxt[alloc_slot_r] = 1'b0;
            owner_we                  = 1'b1;
            // append behind the current tail, or start a new list
            if (tail_ok_r[id_r]) begin
              next_ok_nxt[tail_slot]  = 1'b1;
              next_we                 = 1'b1;
              head_nxt[alloc_slot_r]  = 1'b0;
            end else begin
              head_nxt[alloc_slot_r]  = 1'b1;
            end
            tail_nxt[id_r]    = alloc_slot_r;
            tail_ok_nxt[id_r] = 1'b1;
            used_nxt          = used_r + OCC_W'(1);
            oslot_nxt         = alloc_slot_r;
            oid_nxt           = id_r;
          end
        end
        prrb_pkg::FN_RETURN: begin
          oslot_nxt = slot_r;
          oid_nxt   = id_r;
          if (bad_ret) begin
            status_nxt = prrb_pkg::STS_BAD;
          end else begin
            valid_nxt[slot_r] = 1'b1;
          end
        end
        prrb_pkg::FN_POP: begin
          if (!grant_ok_r) begin
            status_nxt = prrb_pkg::STS_EMPTY;
          end else begin
            // promote the successor, or close the list
            if (next_ok_r[grant_slot_r]) begin
              head_nxt[next_rd_r] = 1'b1;
            end else begin
              tail_ok_nxt[owner_rd_r] = 1'b0;
            end
            head_nxt[grant_slot_r]    = 1'b0;
            valid_nxt[grant_slot_r]   = 1'b0;
            free_nxt[grant_slot_r]    = 1'b1;
            next_ok_nxt[grant_slot_r] = 1'b0;
            if (used_r != '0) used_nxt = used_r - OCC_W'(1);
            rr_nxt    = grant_slot_r;
            oslot_nxt = grant_slot_r;
            oid_nxt   = owner_rd_r;
          end
        end
        default: begin
          status_nxt = prrb_pkg::STS_OK;
        end
      endcase
      occ_nxt = used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r    <= '1;
      valid_r   <= '0;
      head_r    <= '0;
      next_ok_r <= '0;
      tail_ok_r <= '0;
      used_r    <= '0;
      rr_r      <= '0;
    end else begin
      free_r    <= free_nxt;
      valid_r   <= valid_nxt;
      head_r    <= head_nxt;
      next_ok_r <= next_ok_nxt;
      tail_ok_r <= tail_ok_nxt;
      used_r    <= used_nxt;
      rr_r      <= rr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r   <= tail_nxt;
    status_r <= status_nxt;
    oslot_r  <= oslot_nxt;
    oid_r    <= oid_nxt;
    occ_r    <= occ_nxt;
  end

  `PRRB_ASSERT(a_head_not_free, (head_r & free_r) == '0)
  `PRRB_ASSERT(a_valid_not_free, (valid_r & free_r) == '0)
  `PRRB_ASSERT(a_used_matches_free, used_r == (OCC_W'(SLOTS) - OCC_W'($countones(free_r))))

endmodule
`default_nettype wire

@@ src/per_id_read_reorder_buffer_unit.sv @@
// Per-ID read reorder buffer: allocate, data return and pop on one stream.
// Each item passes a lookup state (slot bitmap scans, registered slot memory reads),
// then a commit state that registers its result for out_tvalid and waits while the
// output register holds an untaken result; a new item is taken at that commit.
// Reset (rst_n low, synchronous): all slots free, no lists, occupancy zero,
// round-robin pointer at slot zero; no clearing pass is needed.
`default_nettype none
module per_id_read_reorder_buffer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // func[1:0], txn_id[5:2], slot[11:6], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // status[1:0], out_slot[7:2], out_id[11:8],
                                       // occupancy[18:12], zero pad
);

  prrb_pkg::prrb_cmd_t               cmd;
  logic [1:0]                        res_status;
  logic [prrb_pkg::SLOT_W-1:0]       res_slot;
  logic [prrb_pkg::ID_W-1:0]         res_id;
  logic [prrb_pkg::OCC_W-1:0]        res_occ;

  prrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  prrb_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_func    (in_tdata[1:0]),
    .in_txn_id  (in_tdata[5:2]),
    .in_slot    (in_tdata[11:6]),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_id     (res_id),
    .res_occ    (res_occ)
  );

  assign out_tdata = {5'b0, res_occ, res_id, res_slot, res_status};

endmodule
`default_nettype wire

@@ dv/prrb_result_checker.sv @@
`timescale 1ns / 100ps
module prrb_result_checker
  import prrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // func[1:0], txn_id[5:2], slot[11:6], zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // status[1:0], out_slot[7:2], out_id[11:8],
                                   // occupancy[18:12], zero pad
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [OCC_W-1:0]  occ;
  } rob_answer_t;

  // Shadow copy of the buffer bookkeeping
  logic [SLOTS-1:0]    free_bits;
  logic [SLOTS-1:0]    valid_bits;
  logic [SLOTS-1:0]    head_bits;
  logic [SLOTS-1:0]    link_ok;
  logic [ID_W-1:0]     owner_of [SLOTS];
  logic [SLOT_W-1:0]   next_of [SLOTS];
  logic [SLOT_W-1:0]   tail_of [ID_COUNT];
  logic [ID_COUNT-1:0] tail_ok;
  logic [OCC_W-1:0]    used_slots;
  logic [SLOT_W-1:0]   last_grant;

  rob_answer_t answer_q[$];

  function automatic rob_answer_t apply_item(input logic [1:0] fn,
                                             input logic [ID_W-1:0] id,
                                             input logic [SLOT_W-1:0] s);
    rob_answer_t a;
    int pick;
    int k;
    a = '{status: STS_OK, slot: '0, id: '0, occ: '0};
    pick = -1;
    case (fn)
      FN_ALLOC: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (free_bits[i]) pick = i;
        end
        if (pick < 0) begin
          a.status = STS_FULL;
        end else begin
          free_bits[pick]  = 1'b0;
          valid_bits[pick] = 1'b0;
          // append behind the current tail, or start a new list
          if (tail_ok[id]) begin
            next_of[tail_of[id]] = SLOT_W'(pick);
            link_ok[tail_of[id]] = 1'b1;
            head_bits[pick]      = 1'b0;
          end else begin
            head_bits[pick] = 1'b1;
          end
          tail_of[id]    = SLOT_W'(pick);
          tail_ok[id]    = 1'b1;
          owner_of[pick] = id;
          link_ok[pick]  = 1'b0;
          used_slots++;
          a.slot = SLOT_W'(pick);
          a.id   = id;
        end
      end
      FN_RETURN: begin
        a.slot = s;
        a.id   = id;
        if (free_bits[s] || owner_of[s] != id || valid_bits[s]) begin
          a.status = STS_BAD;
        end else begin
          valid_bits[s] = 1'b1;
        end
      end
      FN_POP: begin
        // scan from the slot after the last grant; keep the nearest hit
        for (int i = SLOTS; i >= 1; i--) begin
          k = (int'(last_grant) + i) % SLOTS;
          if (head_bits[k] && valid_bits[k]) pick = k;
        end
        if (pick < 0) begin
          a.status = STS_EMPTY;
        end else begin
          if (link_ok[pick]) begin
            head_bits[next_of[pick]] = 1'b1;
          end else begin
            tail_ok[owner_of[pick]] = 1'b0;
          end
          head_bits[pick]  = 1'b0;
          valid_bits[pick] = 1'b0;
          free_bits[pick]  = 1'b1;
          link_ok[pick]    = 1'b0;
          if (used_slots != '0) used_slots--;
          last_grant = SLOT_W'(pick);
          a.slot     = SLOT_W'(pick);
          a.id       = owner_of[pick];
        end
      end
      default: ;
    endcase
    a.occ = used_slots;
    return a;
  endfunction

  always @(posedge clk) begin
    rob_answer_t want;
    rob_answer_t got;
    if (!rst_n) begin
      free_bits  = '1;
      valid_bits = '0;
      head_bits  = '0;
      link_ok    = '0;
      tail_ok    = '0;
      used_slots = '0;
      last_grant = '0;
      for (int i = 0; i < SLOTS; i++) begin
        owner_of[i] = '0;
        next_of[i]  = '0;
      end
      for (int i = 0; i < ID_COUNT; i++) tail_of[i] = '0;
      answer_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        answer_q.push_back(apply_item(in_tdata[1:0], in_tdata[5:2], in_tdata[11:6]));
      end
      if (out_tvalid && out_tready) begin
        got = '{status: out_tdata[1:0], slot: out_tdata[7:2],
                id: out_tdata[11:8], occ: out_tdata[18:12]};
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: status %0d slot %0d id %0d occupancy %0d",
                     got.status, got.slot, got.id, got.occ);
          end
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected status %0d slot %0d id %0d occupancy %0d",
                       want.status, want.slot, want.id, want.occ);
              $display("                 got      status %0d slot %0d id %0d occupancy %0d",
                       got.status, got.slot, got.id, got.occ);
            end
          end
        end
      end
    end
    outstanding <= answer_q.size();
  end

endmodule

@@ dv/tb_per_id_read_reorder_buffer_unit.sv @@
`timescale 1ns / 100ps
module tb_per_id_read_reorder_buffer_unit;
  import prrb_pkg::*;

  localparam logic [1:0] FN_NOP    = 2'd3;
  localparam int         QUIET_MAX = 4000;
  localparam int         ROUNDS    = 9;
  localparam int         ROUND_LEN = 100;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;    // func[1:0], txn_id[5:2], slot[11:6], zero pad
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;          // status[1:0], out_slot[7:2], out_id[11:8],
                                   // occupancy[18:12], zero pad
  int          mismatches;
  int          outstanding;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;

  // Funcs in flight, and allocated slots still waiting for their data
  logic [1:0]             func_in_flight_q[$];
  logic [ID_W+SLOT_W-1:0] awaiting_data_q[$];

  always #1 clk = ~clk;

  per_id_read_reorder_buffer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  prrb_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Learn which slots were handed out so returns can target them
  always @(posedge clk) begin
    logic [1:0] fn;
    if (rst_n) begin
      if (in_tvalid && in_tready) func_in_flight_q.push_back(in_tdata[1:0]);
      if (out_tvalid && out_tready && func_in_flight_q.size() != 0) begin
        fn = func_in_flight_q.pop_front();
        if (fn == FN_ALLOC && out_tdata[1:0] == STS_OK) begin
          awaiting_data_q.push_back(out_tdata[11:2]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] fn, input logic [ID_W-1:0] id,
                           input logic [SLOT_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, s, id, fn};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item(input int alloc_pct);
    int                     r;
    int                     idx;
    logic [ID_W-1:0]        id;
    logic [ID_W+SLOT_W-1:0] pending;
    // favor a few IDs so lists grow several entries deep
    id = ($urandom_range(9) < 7) ? ID_W'($urandom_range(3)) : ID_W'($urandom);
    r  = $urandom_range(99);
    if (r < 12) begin
      send_item(2'($urandom), ID_W'($urandom), SLOT_W'($urandom));
    end else if (r < 12 + alloc_pct) begin
      send_item(FN_ALLOC, id, SLOT_W'($urandom));
    end else if (r < 12 + alloc_pct + (88 - alloc_pct) / 2 &&
                 awaiting_data_q.size() != 0) begin
      idx     = $urandom_range(awaiting_data_q.size() - 1);
      pending = awaiting_data_q[idx];
      awaiting_data_q.delete(idx);
      send_item(FN_RETURN, pending[ID_W+SLOT_W-1:SLOT_W], pending[SLOT_W-1:0]);
    end else begin
      send_item(FN_POP, ID_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  initial begin
    int alloc_mix [ROUNDS];
    alloc_mix = '{70, 20, 45, 70, 15, 40, 65, 20, 30};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FN_NOP,    4'd15, 6'd63);
    send_item(FN_POP,    4'd0,  6'd0);   // nothing ready yet
    send_item(FN_ALLOC,  4'd0,  6'd0);
    send_item(FN_ALLOC,  4'd15, 6'd0);
    send_item(FN_ALLOC,  4'd0,  6'd0);   // queued behind the first one of its ID
    send_item(FN_RETURN, 4'd0,  6'd2);
    send_item(FN_POP,    4'd0,  6'd0);   // data back only for a non-head slot
    send_item(FN_RETURN, 4'd15, 6'd0);   // wrong owner
    send_item(FN_RETURN, 4'd0,  6'd63);  // free slot
    send_item(FN_RETURN, 4'd0,  6'd0);
    send_item(FN_RETURN, 4'd0,  6'd0);   // already valid
    send_item(FN_RETURN, 4'd15, 6'd1);
    send_item(FN_POP,    4'd0,  6'd0);
    send_item(FN_POP,    4'd0,  6'd0);   // wraps around, promotes the next slot
    send_item(FN_POP,    4'd0,  6'd0);
    send_item(FN_POP,    4'd0,  6'd0);
    send_item(FN_ALLOC,  4'd7,  6'd0);
    send_item(FN_RETURN, 4'd7,  6'd0);
    send_item(FN_POP,    4'd7,  6'd0);
    drain_results();

    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      case (rnd % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < ROUND_LEN; n++) random_item(alloc_mix[rnd]);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
